@@ rtl/mspfr_pkg.sv @@
// Shared types, constants and helpers of the frame receiver.
package mspfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 7;
    localparam int IDX_OUT_W       = 6;
    localparam int MAX_PAYLOAD_DEF = 64;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 7'd7;
    localparam logic              REG_MAX_LEN    = 1'b0;

    localparam logic [BYTE_W-1:0] HDR_DOLLAR     = 8'h24;
    localparam logic [BYTE_W-1:0] HDR_M          = 8'h4D;
    localparam logic [BYTE_W-1:0] HDR_GT         = 8'h3E;
    localparam logic [BYTE_W-1:0] TYPE_REPLY_MIN = 8'd100;
    localparam logic [BYTE_W-1:0] TYPE_ACK_MIN   = 8'd200;

    typedef enum logic [1:0] {
        CLS_OTHER = 2'd0,
        CLS_REPLY = 2'd1,
        CLS_ACK   = 2'd2
    } msg_class_t;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_M    = 3'd1,
        PH_GT   = 3'd2,
        PH_LEN  = 3'd3,
        PH_TYPE = 3'd4,
        PH_DATA = 3'd5,
        PH_SUM  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_READ = 2'd1,
        BK_LOAD = 2'd2,
        BK_WAIT = 2'd3
    } back_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_type;
        logic [LEN_W-1:0]  len;
    } frame_desc_t;

    function automatic msg_class_t type_class(input logic [BYTE_W-1:0] t);
        msg_class_t c;
        if (t >= TYPE_ACK_MIN)
        begin
            c = CLS_ACK;
        end
        else if (t >= TYPE_REPLY_MIN)
        begin
            c = CLS_REPLY;
        end
        else
        begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

@@ rtl/mspfr_front.sv @@
// Byte parser: header hunt, length check, payload capture and checksum.
module mspfr_front #(
    parameter int MAX_PAYLOAD = mspfr_pkg::MAX_PAYLOAD_DEF,
    parameter int IDX_W       = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          rx_valid,
    output logic                          rx_ready,
    input  logic [mspfr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [mspfr_pkg::LEN_W-1:0]   max_len,
    input  logic                          q_full,
    output logic                          mem_we,
    output logic [IDX_W:0]                mem_waddr,
    output logic [mspfr_pkg::BYTE_W-1:0]  mem_wdata,
    output logic                          push,
    output mspfr_pkg::frame_desc_t        push_desc
);
    import mspfr_pkg::*;

    localparam logic [LEN_W-1:0] LIMIT_CAP = LEN_W'(MAX_PAYLOAD);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    taken_reg, taken_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [BYTE_W-1:0]   type_reg, type_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic                bank_reg, bank_next;
    logic [LEN_W-1:0]    limit;
    logic                accept;

    assign rx_ready  = !q_full;
    assign accept    = rx_valid && rx_ready;
    assign limit     = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
    assign mem_waddr = {bank_reg, taken_reg[IDX_W-1:0]};
    assign mem_wdata = rx_byte;
    assign push_desc = '{msg_type: type_reg, len: len_reg};

    always_comb
    begin
        phase_next = phase_reg;
        taken_next = taken_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        xor_next   = xor_reg;
        bank_next  = bank_reg;
        mem_we     = 1'b0;
        push       = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_HUNT: phase_next = (rx_byte == HDR_DOLLAR) ? PH_M : PH_HUNT;
                PH_M:    phase_next = (rx_byte == HDR_M) ? PH_GT : PH_HUNT;
                PH_GT:   phase_next = (rx_byte == HDR_GT) ? PH_LEN : PH_HUNT;
                PH_LEN:
                begin
                    if (rx_byte > {1'b0, limit})
                    begin
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        len_next   = rx_byte[LEN_W-1:0];
                        xor_next   = rx_byte;
                        taken_next = '0;
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    type_next  = rx_byte;
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = (len_reg == '0) ? PH_SUM : PH_DATA;
                end
                PH_DATA:
                begin
                    mem_we     = 1'b1;
                    xor_next   = xor_reg ^ rx_byte;
                    taken_next = taken_reg + 1'b1;
                    if (taken_next >= len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    phase_next = PH_HUNT;
                    if (rx_byte == xor_reg)
                    begin
                        push      = 1'b1;
                        bank_next = !bank_reg;
                    end
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            taken_reg <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            xor_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            taken_reg <= taken_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            xor_reg   <= xor_next;
            bank_reg  <= bank_next;
        end
    end

endmodule

@@ rtl/mspfr_fifo.sv @@
// Two-entry queue of accepted frame descriptors.
module mspfr_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  mspfr_pkg::frame_desc_t  push_desc,
    input  logic                    pop,
    output logic                    full,
    output logic                    empty,
    output mspfr_pkg::frame_desc_t  head
);
    import mspfr_pkg::*;

    frame_desc_t slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/mspfr_back.sv @@
// Payload store and frame emitter: replays a stored frame one word per result.
module mspfr_back #(
    parameter int IDX_W       = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             mem_we,
    input  logic [IDX_W:0]                   mem_waddr,
    input  logic [mspfr_pkg::BYTE_W-1:0]     mem_wdata,
    input  logic                             q_empty,
    input  mspfr_pkg::frame_desc_t           head,
    output logic                             pop,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mspfr_pkg::BYTE_W-1:0]     msg_type,
    output logic [1:0]                       msg_class,
    output logic [mspfr_pkg::LEN_W-1:0]      payload_len,
    output logic [mspfr_pkg::IDX_OUT_W-1:0]  byte_index,
    output logic [mspfr_pkg::BYTE_W-1:0]     data_byte,
    output logic                             has_data,
    output logic                             last
);
    import mspfr_pkg::*;

    localparam int DEPTH = 2 << IDX_W;

    logic [BYTE_W-1:0]    mem [DEPTH];
    logic [BYTE_W-1:0]    rd_data_reg;

    back_state_t          state_reg, state_next;
    logic [LEN_W-1:0]     k_reg, k_next;
    logic                 bank_reg, bank_next;
    logic                 valid_reg, valid_next;
    logic                 load;
    logic [LEN_W-1:0]     k_inc;

    logic [BYTE_W-1:0]    type_reg;
    logic [1:0]           class_reg;
    logic [LEN_W-1:0]     len_reg;
    logic [IDX_OUT_W-1:0] idx_reg;
    logic [BYTE_W-1:0]    data_reg;
    logic                 has_reg;
    logic                 last_reg;

    assign k_inc = k_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == BK_READ)
        begin
            rd_data_reg <= mem[{bank_reg, k_reg[IDX_W-1:0]}];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        bank_next  = bank_reg;
        valid_next = valid_reg;
        load       = 1'b0;
        pop        = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    k_next     = '0;
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_LOAD;
            BK_LOAD:
            begin
                load       = 1'b1;
                valid_next = 1'b1;
                state_next = BK_WAIT;
            end
            BK_WAIT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                    begin
                        pop        = 1'b1;
                        bank_next  = !bank_reg;
                        state_next = BK_IDLE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        state_next = BK_READ;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            k_reg     <= '0;
            bank_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            bank_reg  <= bank_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            type_reg  <= head.msg_type;
            class_reg <= type_class(head.msg_type);
            len_reg   <= head.len;
            if (head.len == '0)
            begin
                idx_reg  <= '0;
                data_reg <= '0;
                has_reg  <= 1'b0;
                last_reg <= 1'b1;
            end
            else
            begin
                idx_reg  <= k_reg[IDX_OUT_W-1:0];
                data_reg <= rd_data_reg;
                has_reg  <= 1'b1;
                last_reg <= (k_inc == head.len);
            end
        end
    end

    assign out_valid   = valid_reg;
    assign msg_type    = type_reg;
    assign msg_class   = class_reg;
    assign payload_len = len_reg;
    assign byte_index  = idx_reg;
    assign data_byte   = data_reg;
    assign has_data    = has_reg;
    assign last        = last_reg;

endmodule

@@ rtl/msp_v1_frame_receiver_unit.sv @@
// Top level of the frame receiver: register port, parser, frame queue and emitter.
// Input: one byte per cycle while fewer than two good frames wait to be emitted;
// s_tready drops while two frames are queued and frees when the older one is done.
// Output: a good frame is queued once its checksum byte is taken; the emitter then takes
// each result word through store read, output load and handshake before the next one,
// using its single registered read port. Reset clears control state
// and sets max_payload_len to 7; the payload store is not cleared.
module msp_v1_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = mspfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // receive byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // frame result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] msg_type, [9:8] msg_class, [16:10] payload_len,
                                   // [22:17] byte_index, [30:23] data_byte, [31] zero
    output logic        m_tuser,   // [0] has_data
    output logic        m_tlast    // last
);
    import mspfr_pkg::*;

    // Index width of one payload bank; the store holds two banks so that one
    // frame can be replayed while the next is being received.
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [LEN_W-1:0]     max_len_reg;
    logic                 cfg_wr;

    logic                 mem_we;
    logic [IDX_W:0]       mem_waddr;
    logic [BYTE_W-1:0]    mem_wdata;
    logic                 push;
    logic                 pop;
    logic                 q_full;
    logic                 q_empty;
    frame_desc_t          push_desc;
    frame_desc_t          head;

    logic [BYTE_W-1:0]    msg_type;
    logic [1:0]           msg_class;
    logic [LEN_W-1:0]     payload_len;
    logic [IDX_OUT_W-1:0] byte_index;
    logic [BYTE_W-1:0]    data_byte;

    // Register port: zero wait states; address bit 2 picks the register word.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_MAX_LEN) ? {25'd0, max_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_MAX_LEN))
        begin
            max_len_reg <= pwdata[LEN_W-1:0];
        end
    end

    // Front: parse bytes, write payload into the free bank, queue good frames.
    mspfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (s_tvalid),
        .rx_ready  (s_tready),
        .rx_byte   (s_tdata),
        .max_len   (max_len_reg),
        .q_full    (q_full),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .push      (push),
        .push_desc (push_desc)
    );

    // Queue entries stay until their frame is fully emitted, so a full queue
    // also means both payload banks are in use.
    mspfr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    // Back: replay the oldest queued frame, one word per payload byte, one if empty.
    mspfr_back #(
        .IDX_W       (IDX_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .q_empty     (q_empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .msg_type    (msg_type),
        .msg_class   (msg_class),
        .payload_len (payload_len),
        .byte_index  (byte_index),
        .data_byte   (data_byte),
        .has_data    (m_tuser),
        .last        (m_tlast)
    );

    // Pack the result word, first field in the lowest bits.
    assign m_tdata = {1'b0, data_byte, byte_index, payload_len, msg_class, msg_type};

endmodule

@@ dv/mspfr_frame_checker.sv @@
// Frame receiver checker: tracks the parser state, predicts result words, compares them.
`timescale 1ns / 1ps

module mspfr_frame_checker #(
    parameter int MAX_PAYLOAD = mspfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    output int          mismatches,
    output int          pending,
    output int          words_checked,
    output int          frames_good
);
    import mspfr_pkg::*;

    typedef struct {
        logic [BYTE_W-1:0]    msg_type;
        msg_class_t           msg_class;
        logic [LEN_W-1:0]     payload_len;
        logic [IDX_OUT_W-1:0] byte_index;
        logic [BYTE_W-1:0]    data_byte;
        logic                 has_data;
        logic                 last;
    } frame_word_t;

    phase_t            rx_phase;
    logic [LEN_W-1:0]  rx_count;
    logic [LEN_W-1:0]  rx_len;
    logic [LEN_W-1:0]  max_len;
    logic [BYTE_W-1:0] rx_type;
    logic [BYTE_W-1:0] rx_xor;
    logic [BYTE_W-1:0] payload_mem [0:63];
    frame_word_t       expected_words [$];
    int                err_total   = 0;
    int                word_total  = 0;
    int                frame_total = 0;

    function automatic msg_class_t class_of(input logic [BYTE_W-1:0] t);
        if (t >= TYPE_ACK_MIN)
        begin
            return CLS_ACK;
        end
        if (t >= TYPE_REPLY_MIN)
        begin
            return CLS_REPLY;
        end
        return CLS_OTHER;
    endfunction

    function automatic void flag_error(input string msg);
        err_total++;
        if (err_total <= 10)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            flag_error($sformatf("word %0d %s expected %0d, got %0d",
                                 word_total, name, exp_val, act_val));
        end
    endfunction

    // Queue one word per payload byte, or a single data-less word for an empty frame.
    function automatic void queue_frame();
        frame_word_t w;
        int          k;
        w.msg_type    = rx_type;
        w.msg_class   = class_of(rx_type);
        w.payload_len = rx_len;
        if (rx_len == 0)
        begin
            w.byte_index = '0;
            w.data_byte  = '0;
            w.has_data   = 1'b0;
            w.last       = 1'b1;
            expected_words.push_back(w);
        end
        else
        begin
            for (k = 0; k < int'(rx_len); k++)
            begin
                w.byte_index = IDX_OUT_W'(k);
                w.data_byte  = payload_mem[k];
                w.has_data   = 1'b1;
                w.last       = (k == int'(rx_len) - 1);
                expected_words.push_back(w);
            end
        end
        frame_total++;
    endfunction

    function automatic void parse_rx_byte(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] cap;
        cap = (int'(max_len) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : max_len;
        case (rx_phase)
            PH_HUNT: rx_phase = (b == HDR_DOLLAR) ? PH_M : PH_HUNT;
            PH_M:    rx_phase = (b == HDR_M) ? PH_GT : PH_HUNT;
            PH_GT:   rx_phase = (b == HDR_GT) ? PH_LEN : PH_HUNT;
            PH_LEN:
            begin
                if (b > cap)
                begin
                    rx_phase = PH_HUNT;
                end
                else
                begin
                    rx_len   = b[LEN_W-1:0];
                    rx_xor   = b;
                    rx_count = '0;
                    rx_phase = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                rx_type  = b;
                rx_xor   = rx_xor ^ b;
                rx_phase = (rx_len == 0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                payload_mem[rx_count[5:0]] = b;
                rx_xor   = rx_xor ^ b;
                rx_count = rx_count + 1'b1;
                if (rx_count >= rx_len)
                begin
                    rx_phase = PH_SUM;
                end
            end
            PH_SUM:
            begin
                rx_phase = PH_HUNT;
                if (b == rx_xor)
                begin
                    queue_frame();
                end
            end
            default: rx_phase = PH_HUNT;
        endcase
    endfunction

    function automatic void check_word();
        frame_word_t w;
        if (expected_words.size() == 0)
        begin
            flag_error($sformatf("result word %h with no frame expected", m_tdata));
            return;
        end
        w = expected_words.pop_front();
        check_field("msg_type", w.msg_type, m_tdata[7:0]);
        check_field("msg_class", w.msg_class, m_tdata[9:8]);
        check_field("payload_len", w.payload_len, m_tdata[16:10]);
        check_field("byte_index", w.byte_index, m_tdata[22:17]);
        check_field("data_byte", w.data_byte, m_tdata[30:23]);
        check_field("pad bit", 0, m_tdata[31]);
        check_field("has_data", w.has_data, m_tuser);
        check_field("last", w.last, m_tlast);
        word_total++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase = PH_HUNT;
            rx_count = '0;
            rx_len   = '0;
            rx_type  = '0;
            rx_xor   = '0;
            max_len  = MAX_LEN_RESET;
            expected_words.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN)
            begin
                max_len = pwdata[LEN_W-1:0];
            end
            if (s_tvalid && s_tready)
            begin
                parse_rx_byte(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                check_word();
            end
        end
        mismatches    <= err_total;
        pending       <= expected_words.size();
        words_checked <= word_total;
        frames_good   <= frame_total;
    end

endmodule

@@ dv/tb_top.sv @@
// Frame receiver testbench top: clock, reset, byte stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_top;
    import mspfr_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 4;
    localparam int HOLD_CYCLES   = 300;   // long output hold-off, well past two queued frames
    localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either stream
    localparam int SETTLE_CYCLES = 8;     // settle time after the last predicted word, before a register write
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE_BYTES   = 20;
    localparam int NUM_PHASES    = 6;

    localparam logic [2:0] ADDR_MAX_LEN = {REG_MAX_LEN, 2'b00};
    localparam logic [2:0] ADDR_UNUSED  = {~REG_MAX_LEN, 2'b00};

    // Opening sequence, first byte in the top bits: empty frame of the highest
    // "other" type, one all-ones payload byte of the lowest reply type, a repeated
    // dollar sign (dropped, not taken as a new start), a length one above the reset
    // limit, and an empty frame of type 255 with a bad checksum.
    localparam int OPENING_LEN = 26;
    localparam logic [OPENING_LEN*8-1:0] OPENING = {
        HDR_DOLLAR, HDR_M, HDR_GT, 8'h00, TYPE_REPLY_MIN - 8'd1, TYPE_REPLY_MIN - 8'd1,
        HDR_DOLLAR, HDR_M, HDR_GT, 8'h01, TYPE_REPLY_MIN, 8'hFF, 8'h9A,
        HDR_DOLLAR, HDR_DOLLAR, HDR_M,
        HDR_DOLLAR, HDR_M, HDR_GT, 8'h08,
        HDR_DOLLAR, HDR_M, HDR_GT, 8'h00, 8'hFF, 8'h00
    };

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [7:0] msg_type, [9:8] msg_class, [16:10] payload_len,
                             // [22:17] byte_index, [30:23] data_byte, [31] zero
    logic        m_tuser;    // [0] has_data
    logic        m_tlast;    // last

    int mismatches;
    int pending;
    int words_checked;
    int frames_good;

    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_done    = 0;
    int frame_bytes   = 0;
    int noise_bytes   = 0;
    int quiet_cycles  = 0;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    msp_v1_frame_receiver_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mspfr_frame_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked),
        .frames_good   (frames_good)
    );

    // Offer one word on the byte stream and hold it until the block takes it.
    // While idling is enabled, sometimes drop valid for a short random burst first.
    task automatic send_byte(input logic [7:0] b, input bit counted);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        if (counted)
        begin
            frame_bytes++;
        end
        else
        begin
            noise_bytes++;
        end
    endtask

    // Send a whole frame with random payload; corrupt the checksum when asked.
    task automatic send_frame(input int len, input logic [7:0] msg_type, input bit good);
        logic [7:0] check_sum;
        logic [7:0] b;
        int         k;
        check_sum = len[7:0] ^ msg_type;
        send_byte(HDR_DOLLAR, 1'b1);
        send_byte(HDR_M, 1'b1);
        send_byte(HDR_GT, 1'b1);
        send_byte(len[7:0], 1'b1);
        send_byte(msg_type, 1'b1);
        for (k = 0; k < len; k++)
        begin
            b = 8'($urandom_range(0, 255));
            check_sum = check_sum ^ b;
            send_byte(b, 1'b1);
        end
        if (!good)
        begin
            check_sum = check_sum ^ 8'($urandom_range(1, 255));
        end
        send_byte(check_sum, 1'b1);
    endtask

    // Favor the class boundaries and the type extremes, else any byte.
    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0:       return TYPE_REPLY_MIN - 8'd1;
            1:       return TYPE_REPLY_MIN;
            2:       return TYPE_ACK_MIN - 8'd1;
            3:       return TYPE_ACK_MIN;
            4:       return 8'h00;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] hdr);
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        return (b == hdr) ? ~b : b;
    endfunction

    // Mostly well-formed frames with random content; the rest is line noise,
    // broken headers and lengths above the current limit.
    task automatic run_traffic(input int budget, input int cap);
        int start;
        int len;
        int pick;
        start = frame_bytes;
        while (frame_bytes - start < budget)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
            begin
                case ($urandom_range(0, 9))
                    0:       len = cap;
                    1:       len = 0;
                    default: len = $urandom_range(0, (cap < 6) ? cap : 6);
                endcase
                send_frame(len, pick_type(), $urandom_range(0, 7) != 0);
            end
            else if (pick == 16)
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            else if (pick == 17)
            begin
                send_byte(HDR_DOLLAR, 1'b1);
                if ($urandom_range(0, 1) == 0)
                begin
                    send_byte(other_than(HDR_M), 1'b1);
                end
                else
                begin
                    send_byte(HDR_M, 1'b1);
                    send_byte(other_than(HDR_GT), 1'b1);
                end
            end
            else
            begin
                send_byte(HDR_DOLLAR, 1'b1);
                send_byte(HDR_M, 1'b1);
                send_byte(HDR_GT, 1'b1);
                send_byte(8'($urandom_range(cap + 1, 255)), 1'b1);
            end
        end
    endtask

    // Drop valid, wait until every predicted word has come out, then let the
    // block settle before touching the register.
    task automatic wait_quiet(input int settle);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Setup then access cycle; leave the bus selected so writes can run back to back.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // Receiver: random short stalls, one long hold-off on request, and a
    // steady ready once idling is switched off for the final phase.
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (holds_done != hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no word moves on either stream for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no word accepted for %0d cycles", STALL_LIMIT);
            $display("msp_v1_frame_receiver_unit test failed");
            $finish;
        end
    end

    initial
    begin
        int i;
        int ph;
        int setting;
        int cap;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening at the reset limit of 7.
        for (i = 0; i < OPENING_LEN; i++)
        begin
            send_byte(OPENING[8*(OPENING_LEN-1-i) +: 8], 1'b1);
        end

        // Random phases: full size, zero, a value above the size limit, a small
        // limit under a long output hold-off, a random one, and a final phase
        // without any idling.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       setting = MAX_PAYLOAD_DEF;
                1:       setting = 0;
                2:       setting = 127;
                3:       setting = 5;
                4:       setting = $urandom_range(1, MAX_PAYLOAD_DEF - 1);
                default: setting = 12;
            endcase
            wait_quiet(SETTLE_CYCLES);
            if (ph == 2)
            begin
                // A write to an unmapped index must leave the limit alone.
                write_reg(ADDR_UNUSED, $urandom());
            end
            write_reg(ADDR_MAX_LEN, {25'($urandom()), 7'(setting)});
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            cap = (setting > MAX_PAYLOAD_DEF) ? MAX_PAYLOAD_DEF : setting;
            if (ph == NUM_PHASES - 1)
            begin
                idle_on = 1'b0;
            end
            if (ph == 2)
            begin
                send_frame(cap, pick_type(), 1'b1);
            end
            if (ph == 3)
            begin
                // Stall the output so queued frames back up into the byte stream:
                // two good frames fill the queue and the third waits at the input.
                hold_requests++;
                repeat (3) send_frame(cap, pick_type(), 1'b1);
            end
            run_traffic(PHASE_BYTES, cap);
        end

        wait_quiet(DRAIN_CYCLES);

        $display("Sent %0d frame bytes and %0d noise bytes over %0d limit settings",
                 frame_bytes, noise_bytes, NUM_PHASES);
        $display("Checked %0d result words from %0d good frames, %0d mismatches",
                 words_checked, frames_good, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("msp_v1_frame_receiver_unit test passed");
        end
        else
        begin
            $display("msp_v1_frame_receiver_unit test failed");
        end
        $finish;
    end

endmodule
